// ===== src/tsq_pkg.sv =====
package tsq_pkg;

    // Queue size and the width of a counter that can hold it.
    localparam int DEPTH = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths fixed by the interface.
    localparam int STAMP_W = 48;
    localparam int REF_W   = 32;
    localparam int FILL_W  = 6;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_DRAINED  = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [STAMP_W-1:0] stamp;
        logic [REF_W-1:0]   tx_ref;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [STAMP_W-1:0] out_stamp;
        logic [REF_W-1:0]   out_ref;
        logic [FILL_W-1:0]  fill;
        logic               last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the new entry and its compare vector
        logic insert;      // place the captured entry, or drop it if full
        logic drain_step;  // emit the head entry and shift the queue down
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;       // no entries stored
        logic one_left;    // exactly one entry stored
        logic out_free;    // output register can take a result this cycle
    } t_dp_status;

endpackage

// ===== src/timestamp_sorted_queue.sv =====
// Timestamp-ordered queue of up to DEPTH entries (48-bit stamp, 32-bit handle).
// Input channel (i_in_valid / o_in_ready, payload i_in) carries commands:
// an insert places the entry after every stored entry with a stamp less than
// or equal to it, so equal stamps keep arrival order; a drain emits all
// entries in ascending order and empties the queue.
// Output channel (o_out_valid / i_out_ready, payload o_out) carries results:
// one status result per insert, one result per entry for a drain, with last
// set on the final result of each command. A drain of an empty queue gives
// no result at all.
// Operation: an insert first captures a parallel compare of all stored stamps
// when it is accepted, then shifts and places the entry once the output register
// is free; its result is registered by the shift-and-place. A drain streams one
// entry per cycle through the shifting entry array while the receiver takes them.
// Commands are handled one at a time: the input is ready only while the
// controller is idle, which includes while a finished result waits.
// When the receiver stalls, the single output register holds its result and
// insert or drain progress pauses until it is taken.
// Reset (synchronous, active low) empties the queue and the output register.
module timestamp_sorted_queue
    import tsq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencing of insert and drain transactions.
    tsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_in.cmd),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_dp_cmd   (dp_cmd)
    );

    // Entry storage, compare and shift logic, and the output register.
    tsq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stamp     (i_in.stamp),
        .i_tx_ref    (i_in.tx_ref),
        .i_dp_cmd    (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== src/tsq_ctrl.sv =====
module tsq_ctrl
    import tsq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_cmd,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_dp_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_INS   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // Command decode and next state.
    always_comb begin
        n_state             = r_state;
        o_dp_cmd.load       = 1'b0;
        o_dp_cmd.insert     = 1'b0;
        o_dp_cmd.drain_step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_cmd == CMD_INSERT) begin
                        o_dp_cmd.load = 1'b1;
                        n_state       = S_INS;
                    end else if (!i_status.empty) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_INS: begin
                if (i_status.out_free) begin
                    o_dp_cmd.insert = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (i_status.out_free) begin
                    o_dp_cmd.drain_step = 1'b1;
                    if (i_status.one_left) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/tsq_datapath.sv =====
module tsq_datapath
    import tsq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [STAMP_W-1:0] i_stamp,
    input  logic [REF_W-1:0]   i_tx_ref,
    input  t_dp_cmd            i_dp_cmd,
    output t_dp_status         o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out
);

    logic [STAMP_W-1:0] r_stamp [DEPTH];
    logic [REF_W-1:0]   r_ref   [DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [DEPTH-1:0]   r_gt;
    logic [DEPTH-1:0]   n_gt;
    logic [STAMP_W-1:0] r_new_stamp;
    logic [REF_W-1:0]   r_new_ref;
    t_out_item          r_out;
    logic               r_out_valid;
    logic               full;

    assign full              = (r_count >= CNT_W'(DEPTH));
    assign o_status.empty    = (r_count == '0);
    assign o_status.one_left = (r_count == CNT_W'(1));
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

    // Compare the incoming stamp against every stored entry at once.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_gt[i] = (CNT_W'(i) < r_count) && (r_stamp[i] > i_stamp);
        end
    end

    // Entry array: insert shifts the tail up by one, drain shifts down by one.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_gt        <= n_gt;
            r_new_stamp <= i_stamp;
            r_new_ref   <= i_tx_ref;
        end
        if (i_dp_cmd.insert && !full) begin
            for (int j = 0; j < DEPTH; j++) begin
                if (j > 0 && r_gt[(j > 0) ? j - 1 : 0]) begin
                    r_stamp[j] <= r_stamp[(j > 0) ? j - 1 : 0];
                    r_ref[j]   <= r_ref[(j > 0) ? j - 1 : 0];
                end else if (r_gt[j] || CNT_W'(j) == r_count) begin
                    r_stamp[j] <= r_new_stamp;
                    r_ref[j]   <= r_new_ref;
                end
            end
        end else if (i_dp_cmd.drain_step) begin
            for (int j = 0; j < DEPTH - 1; j++) begin
                r_stamp[j] <= r_stamp[j + 1];
                r_ref[j]   <= r_ref[j + 1];
            end
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_cmd.insert && !full) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_dp_cmd.drain_step) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Output register holds one result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.insert || i_dp_cmd.drain_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.insert) begin
            r_out.out_stamp <= '0;
            r_out.out_ref   <= '0;
            r_out.last      <= 1'b1;
            if (full) begin
                r_out.status <= ST_DROPPED;
                r_out.fill   <= FILL_W'(r_count);
            end else begin
                r_out.status <= ST_ACCEPTED;
                r_out.fill   <= FILL_W'(r_count + CNT_W'(1));
            end
        end else if (i_dp_cmd.drain_step) begin
            r_out.status    <= ST_DRAINED;
            r_out.out_stamp <= r_stamp[0];
            r_out.out_ref   <= r_ref[0];
            r_out.fill      <= FILL_W'(r_count - CNT_W'(1));
            r_out.last      <= (r_count == CNT_W'(1));
        end
    end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsq_pkg::*;

    // The longest correct run stays far below this: about 500 commands, each
    // with a sender gap of at most MAX_SEND_GAP and up to 32 results under random stall.
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_SEND_GAP = 30;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS = 115;

    // Keeps its own copy of the queue contents and the results they imply.
    class queue_order_checker;
        logic [STAMP_W-1:0] model_stamps[$];
        logic [REF_W-1:0]   model_refs[$];
        t_out_item          pending_results[$];
        int mismatch_count;
        int results_checked;
        int inserts_placed;
        int inserts_dropped;
        int entries_drained;
        int deepest_fill;

        task report_mismatch(string what);
            $display("[%0t] MISMATCH on result %0d: %s", $time, results_checked, what);
            mismatch_count++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
            end
        endtask

        // Work out the results of one accepted command and update the queue copy.
        function void apply_command(t_in_item item);
            t_out_item res;
            int pos;
            int n;
            res = '0;
            if (item.cmd == CMD_INSERT) begin
                res.last = 1'b1;
                if (model_stamps.size() >= DEPTH) begin
                    res.status = ST_DROPPED;
                    inserts_dropped++;
                end else begin
                    // The new entry goes after every stored entry with a stamp <= its own.
                    pos = model_stamps.size();
                    while (pos > 0 && model_stamps[pos-1] > item.stamp) begin
                        pos--;
                    end
                    model_stamps.insert(pos, item.stamp);
                    model_refs.insert(pos, item.tx_ref);
                    res.status = ST_ACCEPTED;
                    inserts_placed++;
                end
                res.fill = FILL_W'(model_stamps.size());
                if (model_stamps.size() > deepest_fill) begin
                    deepest_fill = model_stamps.size();
                end
                pending_results.push_back(res);
            end else begin
                // A drain streams every entry in order; an empty queue gives nothing.
                n = model_stamps.size();
                for (int k = 0; k < n; k++) begin
                    res.status    = ST_DRAINED;
                    res.out_stamp = model_stamps[k];
                    res.out_ref   = model_refs[k];
                    res.fill      = FILL_W'(n - 1 - k);
                    res.last      = (k == n - 1);
                    pending_results.push_back(res);
                end
                entries_drained += n;
                model_stamps.delete();
                model_refs.delete();
            end
        endfunction

        // Compare one accepted result with the oldest pending one.
        task check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %h arrived with nothing pending", got));
            end else begin
                want = pending_results.pop_front();
                compare_field("status", 64'(got.status), 64'(want.status));
                compare_field("out_stamp", 64'(got.out_stamp), 64'(want.out_stamp));
                compare_field("out_ref", 64'(got.out_ref), 64'(want.out_ref));
                compare_field("fill", 64'(got.fill), 64'(want.fill));
                compare_field("last", 64'(got.last), 64'(want.last));
            end
            results_checked++;
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;

    queue_order_checker checker_q;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_off_cycles;
    int commands_sent;
    int cycle_count;

    timestamp_sorted_queue DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Free-running clock.
    always #5ns i_clk = ~i_clk;

    // Stop the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check every result transaction accepted by the receiver.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            checker_q.check_result(o_out);
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // Stamps are drawn from a small pool part of the time so that ties are common.
    function automatic logic [STAMP_W-1:0] pick_stamp();
        int unsigned sel;
        logic [63:0] wide;
        sel = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (sel < 30) begin
            return STAMP_W'($urandom_range(0, 7) * 1000);
        end else if (sel < 35) begin
            return '0;
        end else if (sel < 40) begin
            return '1;
        end
        return wide[STAMP_W-1:0];
    endfunction

    // Offer one command transaction, called and returning at a falling edge.
    task automatic send_command(logic cmd, logic [STAMP_W-1:0] stamp);
        int gap;
        t_in_item item;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(0, 99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item.cmd    = cmd;
        item.stamp  = stamp;
        item.tx_ref = $urandom;
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) begin
            @(posedge i_clk);
        end
        checker_q.apply_command(item);
        commands_sent++;
        @(negedge i_clk);
    endtask

    // Mostly well-formed insert bursts ending in a drain, with some noise.
    task automatic run_phase(int target, int idle_pct, int stall_pct);
        int start_count;
        int seq;
        int kind;
        int n;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start_count        = commands_sent;
        seq                = 0;
        while (commands_sent - start_count < target) begin
            kind = $urandom_range(0, 99);
            if (seq == 0 || kind < 10) begin
                // Fill past full so that some inserts are dropped.
                n = DEPTH - checker_q.model_stamps.size() + $urandom_range(1, 3);
                repeat (n) send_command(CMD_INSERT, pick_stamp());
                send_command(CMD_DRAIN, pick_stamp());
            end else if (kind < 85) begin
                n = $urandom_range(1, 8);
                repeat (n) send_command(CMD_INSERT, pick_stamp());
                send_command(CMD_DRAIN, pick_stamp());
            end else begin
                send_command(logic'($urandom_range(0, 1)), pick_stamp());
            end
            seq++;
        end
    endtask

    initial begin
        checker_q          = new();
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_in               = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_cycles    = 0;
        commands_sent      = 0;
        cycle_count        = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: drain of an empty queue, extreme stamps, insert at the
        // front, ties with the tail, the head and a middle entry.
        send_command(CMD_DRAIN, '1);
        send_command(CMD_INSERT, '1);
        send_command(CMD_INSERT, '0);
        send_command(CMD_INSERT, 48'h0000_8000_0000);
        send_command(CMD_INSERT, '1);
        send_command(CMD_INSERT, '0);
        send_command(CMD_INSERT, 48'h0000_8000_0000);
        send_command(CMD_INSERT, 48'h0000_0000_0001);
        send_command(CMD_DRAIN, '0);
        send_command(CMD_DRAIN, '0);

        // Random phases; the first opens with a long receiver hold-off so the
        // block fills its output and stalls the input side.
        hold_off_cycles = HOLD_OFF_CYCLES;
        run_phase(PHASE_ITEMS, 0, 0);
        run_phase(PHASE_ITEMS, 52, 0);
        run_phase(PHASE_ITEMS, 0, 52);
        run_phase(PHASE_ITEMS, 22, 22);
        send_command(CMD_DRAIN, '0);
        i_in_valid <= 1'b0;

        // Wait for the last results, then keep the clock running to catch stray ones.
        while (checker_q.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("Sent %0d commands: %0d inserts placed, %0d dropped on a full queue.",
                 commands_sent, checker_q.inserts_placed, checker_q.inserts_dropped);
        $display("Checked %0d results, %0d drained entries, deepest fill %0d, %0d mismatches.",
                 checker_q.results_checked, checker_q.entries_drained,
                 checker_q.deepest_fill, checker_q.mismatch_count);
        if (checker_q.mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tsq_pkg.sv
src/tsq_ctrl.sv
src/tsq_datapath.sv
src/timestamp_sorted_queue.sv
bench/tb_top.sv
